[hw/rtl/kc_pkg.sv]
package kc_pkg;

    // Table geometry and field widths.
    localparam int TABLE_AW    = 12;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int COUNT_BITS  = 32;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 6;
    localparam int FILL_W      = 6;
    localparam int IDX_W       = 12;
    localparam int OUT_CNT_W   = 32;
    localparam int DISTINCT_W  = 13;
    localparam int PROBE_W     = TABLE_AW + 1;

    localparam logic [LEN_W-1:0]      LEN_RESET    = LEN_W'(25);
    localparam logic [LEN_W-1:0]      LEN_MAX      = LEN_W'(32);
    localparam logic [FILL_W-1:0]     FILL_MAX     = FILL_W'(32);
    localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = {DISTINCT_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

    // Hash: home slot is bits [32 +: TABLE_AW] of key * HASH_MULT.
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
    localparam int PROD_W  = 32 + TABLE_AW;
    localparam int HALF_W  = (PROD_W + 1) / 2;
    localparam int UPPER_W = PROD_W - HALF_W;

    // One table word: valid, key, count.
    localparam int WORD_W = 1 + KEY_W + COUNT_BITS;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH0,
        ST_HASH1,
        ST_HASH2,
        ST_HOME,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH
    } t_mul_sel;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_READ,
        RES_NEW,
        RES_HIT,
        RES_FULL
    } t_res_kind;

    typedef struct packed {
        logic      clr_en;
        logic      accept;
        logic      mul_en;
        t_mul_sel  mul_sel;
        logic      home_load;
        logic      wr_new;
        logic      wr_hit;
        logic      probe_next;
        logic      res_set;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic win_ready;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/kc_ram.sv]
module kc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/kc_ctrl.sv]
module kc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_op,
    output logic             o_ready,
    output logic             o_cfg_ready,
    input  kc_pkg::t_dp_stat i_stat,
    output kc_pkg::t_dp_cmd  o_cmd
);

    kc_pkg::t_state r_state;
    kc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cfg_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_sel  = kc_pkg::MUL_LL;
        o_cmd.res_kind = kc_pkg::RES_ZERO;
        unique case (r_state)
            kc_pkg::ST_CLEAR: begin
                o_cfg_ready  = 1'b1;
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = kc_pkg::ST_IDLE;
                end
            end
            kc_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_cfg_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_op ? kc_pkg::ST_READ : kc_pkg::ST_HASH0;
                end
            end
            kc_pkg::ST_HASH0: begin
                if (!i_stat.win_ready) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = kc_pkg::RES_ZERO;
                    n_state = kc_pkg::ST_DONE;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = kc_pkg::MUL_LL;
                    n_state = kc_pkg::ST_HASH1;
                end
            end
            kc_pkg::ST_HASH1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = kc_pkg::MUL_HL;
                n_state = kc_pkg::ST_HASH2;
            end
            kc_pkg::ST_HASH2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = kc_pkg::MUL_LH;
                n_state = kc_pkg::ST_HOME;
            end
            kc_pkg::ST_HOME: begin
                o_cmd.home_load = 1'b1;
                n_state = kc_pkg::ST_READ;
            end
            kc_pkg::ST_READ: begin
                n_state = kc_pkg::ST_CHECK;
            end
            kc_pkg::ST_CHECK: begin
                o_cmd.res_set = 1'b1;
                n_state = kc_pkg::ST_DONE;
                if (i_stat.is_read) begin
                    o_cmd.res_kind = kc_pkg::RES_READ;
                end else if (!i_stat.slot_valid) begin
                    o_cmd.wr_new   = 1'b1;
                    o_cmd.res_kind = kc_pkg::RES_NEW;
                end else if (i_stat.key_match) begin
                    o_cmd.wr_hit   = 1'b1;
                    o_cmd.res_kind = kc_pkg::RES_HIT;
                end else if (i_stat.probe_last) begin
                    o_cmd.res_kind = kc_pkg::RES_FULL;
                end else begin
                    o_cmd.res_set    = 1'b0;
                    o_cmd.probe_next = 1'b1;
                    n_state = kc_pkg::ST_READ;
                end
            end
            kc_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = kc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

[hw/rtl/kc_datapath.sv]
module kc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kc_pkg::t_dp_cmd                   i_cmd,
    output kc_pkg::t_dp_stat                  o_stat,
    input  logic                              i_cfg_valid,
    input  logic [kc_pkg::LEN_W-1:0]          i_cfg_data,
    input  logic                              i_op,
    input  logic [2:0]                        i_base_code,
    input  logic                              i_read_start,
    input  logic [kc_pkg::IDX_W-1:0]          i_entry_index,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_key_valid,
    output logic [kc_pkg::KEY_W-1:0]          o_kmer_key,
    output logic [kc_pkg::OUT_CNT_W-1:0]      o_kmer_count,
    output logic                              o_is_new,
    output logic                              o_table_full,
    output logic [kc_pkg::DISTINCT_W-1:0]     o_distinct_total
);

    localparam int AW = kc_pkg::TABLE_AW;
    localparam int KW = kc_pkg::KEY_W;
    localparam int CW = kc_pkg::COUNT_BITS;
    localparam int HW = kc_pkg::HALF_W;
    localparam int UW = kc_pkg::UPPER_W;
    localparam int PW = kc_pkg::PROD_W;

    logic [kc_pkg::LEN_W-1:0]      r_len;
    logic [KW-1:0]                 r_window;
    logic [kc_pkg::FILL_W-1:0]     r_fill;
    logic                          r_is_read;
    logic [AW-1:0]                 r_idx;
    logic                          r_idx_ok;
    logic [PW-1:0]                 r_p0;
    logic [UW-1:0]                 r_p1;
    logic [UW-1:0]                 r_p2;
    logic [AW-1:0]                 r_pos;
    logic [kc_pkg::PROBE_W-1:0]    r_probe;
    logic [AW-1:0]                 r_clr;
    logic [kc_pkg::DISTINCT_W-1:0] r_distinct;
    logic [kc_pkg::DISTINCT_W-1:0] n_distinct;

    logic                          r_pend_kv;
    logic [KW-1:0]                 r_pend_key;
    logic [CW-1:0]                 r_pend_cnt;
    logic                          r_pend_new;
    logic                          r_pend_full;
    logic [kc_pkg::DISTINCT_W-1:0] r_pend_dist;

    logic                          r_out_valid;
    logic                          r_out_kv;
    logic [KW-1:0]                 r_out_key;
    logic [CW-1:0]                 r_out_cnt;
    logic                          r_out_new;
    logic                          r_out_full;
    logic [kc_pkg::DISTINCT_W-1:0] r_out_dist;

    logic [kc_pkg::LEN_W-1:0]  eff_len;
    logic [KW-1:0]             key_mask;
    logic [KW-1:0]             key;
    logic [HW-1:0]             mul_a;
    logic [HW-1:0]             mul_c;
    logic [2*HW-1:0]           mul_p;
    logic [PW-1:0]             hash_sum;
    logic [UW-1:0]             cross_sum;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [kc_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [kc_pkg::WORD_W-1:0] ram_rdata;
    logic                      slot_valid;
    logic [KW-1:0]             slot_key;
    logic [CW-1:0]             slot_cnt;
    logic [CW-1:0]             cnt_inc;

    // Effective k-mer length and the key mask it gives.
    always_comb begin
        if (r_len == '0) begin
            eff_len = kc_pkg::LEN_W'(1);
        end else if (r_len > kc_pkg::LEN_MAX) begin
            eff_len = kc_pkg::LEN_MAX;
        end else begin
            eff_len = r_len;
        end
        for (int i = 0; i < KW; i++) begin
            key_mask[i] = (kc_pkg::LEN_W'(i >> 1) < eff_len);
        end
    end

    assign key = r_window & key_mask;

    // Shared multiplier for the three partial products of the hash.
    always_comb begin
        unique case (i_cmd.mul_sel)
            kc_pkg::MUL_LL: begin
                mul_a = key[HW-1:0];
                mul_c = kc_pkg::HASH_MULT[HW-1:0];
            end
            kc_pkg::MUL_HL: begin
                mul_a = HW'(key[PW-1:HW]);
                mul_c = kc_pkg::HASH_MULT[HW-1:0];
            end
            kc_pkg::MUL_LH: begin
                mul_a = key[HW-1:0];
                mul_c = HW'(kc_pkg::HASH_MULT[PW-1:HW]);
            end
            default: begin
                mul_a = '0;
                mul_c = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_c;
    assign cross_sum = r_p1 + r_p2;
    assign hash_sum  = r_p0 + {cross_sum, {HW{1'b0}}};

    // Table word fields and the saturating increment.
    assign slot_valid = ram_rdata[kc_pkg::WORD_W-1];
    assign slot_key   = ram_rdata[CW +: KW];
    assign slot_cnt   = ram_rdata[CW-1:0];
    assign cnt_inc    = (slot_cnt == kc_pkg::COUNT_MAX) ? slot_cnt : slot_cnt + CW'(1);

    always_comb begin
        n_distinct = r_distinct;
        if (i_cmd.wr_new && r_distinct != kc_pkg::DISTINCT_MAX) begin
            n_distinct = r_distinct + kc_pkg::DISTINCT_W'(1);
        end
    end

    // Table port selection: clearing sweep, new entry or count update.
    always_comb begin
        ram_we    = i_cmd.clr_en | i_cmd.wr_new | i_cmd.wr_hit;
        ram_waddr = i_cmd.clr_en ? r_clr : r_pos;
        if (i_cmd.wr_new) begin
            ram_wdata = {1'b1, key, CW'(1)};
        end else if (i_cmd.wr_hit) begin
            ram_wdata = {1'b1, key, cnt_inc};
        end else begin
            ram_wdata = '0;
        end
        ram_raddr = r_is_read ? r_idx : r_pos;
    end

    kc_ram #(
        .WIDTH (kc_pkg::WORD_W),
        .DEPTH (kc_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers: length, window, fill, counters, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= kc_pkg::LEN_RESET;
            r_window    <= '0;
            r_fill      <= '0;
            r_clr       <= '0;
            r_distinct  <= '0;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.accept) begin
                r_is_read <= i_op;
                if (!i_op) begin
                    if (i_read_start) begin
                        r_window <= KW'(i_base_code[1:0]);
                        r_fill   <= kc_pkg::FILL_W'(1);
                    end else begin
                        r_window <= {r_window[KW-3:0], i_base_code[1:0]};
                        if (r_fill < kc_pkg::FILL_MAX) begin
                            r_fill <= r_fill + kc_pkg::FILL_W'(1);
                        end
                    end
                end
            end
            r_distinct <= n_distinct;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: index, hash products, probe position, results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx    <= AW'(i_entry_index);
            r_idx_ok <= (32'(i_entry_index) < 32'(kc_pkg::TABLE_DEPTH));
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                kc_pkg::MUL_LL: r_p0 <= mul_p[PW-1:0];
                kc_pkg::MUL_HL: r_p1 <= mul_p[UW-1:0];
                kc_pkg::MUL_LH: r_p2 <= mul_p[UW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.home_load) begin
            r_pos   <= hash_sum[PW-1:32];
            r_probe <= '0;
        end else if (i_cmd.probe_next) begin
            r_pos   <= r_pos + AW'(1);
            r_probe <= r_probe + kc_pkg::PROBE_W'(1);
        end
        if (i_cmd.res_set) begin
            r_pend_dist <= n_distinct;
            r_pend_kv   <= 1'b0;
            r_pend_key  <= '0;
            r_pend_cnt  <= '0;
            r_pend_new  <= 1'b0;
            r_pend_full <= 1'b0;
            case (i_cmd.res_kind)
                kc_pkg::RES_READ: begin
                    if (r_idx_ok && slot_valid) begin
                        r_pend_kv  <= 1'b1;
                        r_pend_key <= slot_key;
                        r_pend_cnt <= slot_cnt;
                    end
                end
                kc_pkg::RES_NEW: begin
                    r_pend_kv  <= 1'b1;
                    r_pend_key <= key;
                    r_pend_cnt <= CW'(1);
                    r_pend_new <= 1'b1;
                end
                kc_pkg::RES_HIT: begin
                    r_pend_kv  <= 1'b1;
                    r_pend_key <= key;
                    r_pend_cnt <= cnt_inc;
                end
                kc_pkg::RES_FULL: begin
                    r_pend_key  <= key;
                    r_pend_full <= 1'b1;
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_kv   <= r_pend_kv;
            r_out_key  <= r_pend_key;
            r_out_cnt  <= r_pend_cnt;
            r_out_new  <= r_pend_new;
            r_out_full <= r_pend_full;
            r_out_dist <= r_pend_dist;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.clr_last   = (r_clr == AW'(kc_pkg::TABLE_DEPTH - 1));
        o_stat.is_read    = r_is_read;
        o_stat.win_ready  = (r_fill >= eff_len);
        o_stat.slot_valid = slot_valid;
        o_stat.key_match  = (slot_key == key);
        o_stat.probe_last = (r_probe == kc_pkg::PROBE_W'(kc_pkg::TABLE_DEPTH - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_valid      = r_out_kv;
    assign o_kmer_key       = r_out_key;
    assign o_kmer_count     = kc_pkg::OUT_CNT_W'(r_out_cnt);
    assign o_is_new         = r_out_new;
    assign o_table_full     = r_out_full;
    assign o_distinct_total = r_out_dist;

endmodule

[hw/rtl/kmer_counter_top.sv]
// A read beat passes through READ, CHECK and DONE. A push beat goes from HASH0 straight to
// DONE while the window fills; once counted it passes HASH1, HASH2, HOME, then READ and CHECK
// for each probe, then DONE. The block handles one item at a time; the next beat is taken in
// the cycle after the result loads. The hash uses one shared multiplier for its three
// partial products, and each probe reads a slot and then checks it.
// Reset: synchronous, active low; afterwards a clearing pass empties all 4096 slots of the
// table and no input beat is accepted during it. Configuration writes are taken only
// during the clearing pass and while the block is idle.
module kmer_counter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kc_pkg::LEN_W-1:0]          i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [2:0]                        i_base_code,
    input  logic                              i_read_start,
    input  logic [kc_pkg::IDX_W-1:0]          i_entry_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_key_valid,
    output logic [kc_pkg::KEY_W-1:0]          o_kmer_key,
    output logic [kc_pkg::OUT_CNT_W-1:0]      o_kmer_count,
    output logic                              o_is_new,
    output logic                              o_table_full,
    output logic [kc_pkg::DISTINCT_W-1:0]     o_distinct_total
);

    kc_pkg::t_dp_cmd  cmd;
    kc_pkg::t_dp_stat stat;
    logic             cfg_take;

    // The length register is written only when the write beat is taken.
    assign cfg_take = i_cfg_valid & o_cfg_ready;

    kc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .o_ready     (o_ready),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (cfg_take),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_base_code      (i_base_code),
        .i_read_start     (i_read_start),
        .i_entry_index    (i_entry_index),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_key_valid      (o_key_valid),
        .o_kmer_key       (o_kmer_key),
        .o_kmer_count     (o_kmer_count),
        .o_is_new         (o_is_new),
        .o_table_full     (o_table_full),
        .o_distinct_total (o_distinct_total)
    );

    // A new entry is only written into a slot that read back as free.
    a_new_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_new |-> !stat.slot_valid)
        else $error("new entry written over a valid slot");

    // A fresh insert is counted once and never flagged as table full.
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_new) |-> (o_key_valid && !o_table_full && o_kmer_count == 1))
        else $error("inserted k-mer reported with wrong flags or count");

    // A dropped k-mer is not reported as counted.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_key_valid && !o_is_new))
        else $error("table full result marked as counted");

    // No input beat is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_en |-> !o_ready)
        else $error("input accepted during clearing pass");

endmodule
